// ===== rtl/ahdsr_pkg.sv =====
// Shared types and constants for the AHDSR envelope generator.
// Used by the top level, the multiply/divide unit and the port checker.
`default_nettype none

package ahdsr_pkg;

    localparam int DEF_TIME_BITS           = 24;
    localparam int DEF_LEGATO_ATTACK_TICKS = 240;

    // Amplitude is Q1.15; unity is one step above the largest fraction.
    localparam logic [15:0] FULL_LEVEL = 16'h8000;
    localparam int          AMP_BITS   = 16;
    localparam int          QUOT_BITS  = 16;

    localparam int RST_DELAY_TICKS   = 0;
    localparam int RST_ATTACK_TICKS  = 480;
    localparam int RST_HOLD_TICKS    = 0;
    localparam int RST_DECAY_TICKS   = 4800;
    localparam int RST_SUSTAIN_LEVEL = 16384;
    localparam int RST_RELEASE_TICKS = 4800;
    localparam int RST_FORCE_TICKS   = 480;

    typedef enum logic [2:0] {
        CFG_DELAY         = 3'd0,
        CFG_ATTACK        = 3'd1,
        CFG_HOLD          = 3'd2,
        CFG_DECAY         = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4,
        CFG_CAN_SUSTAIN   = 3'd5,
        CFG_RELEASE       = 3'd6,
        CFG_FORCE_RELEASE = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_DELAY   = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_HOLD    = 3'd2,
        PH_DECAY   = 3'd3,
        PH_SUSTAIN = 3'd4,
        PH_RELEASE = 3'd5,
        PH_FORCED  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END_ATTACK,
        ST_END_HOLD,
        ST_END_DECAY,
        ST_EVAL,
        ST_CALC,
        ST_DONE
    } state_t;

    // Bit positions of the result fields inside m_tdata.
    localparam int OUT_PHASE_LSB = 16;
    localparam int OUT_FIN_BIT   = 19;

endpackage

`default_nettype wire

// ===== rtl/ahdsr_envelope_generator.sv =====
// AHDSR envelope generator, one amplitude result per sample tick request.
// A taken request passes the attack, hold and decay end-point states and the
// evaluation state; a ramp then waits in the calculate state while the
// multiply/divide unit multiplies, loads and divides for the 16-bit quotient.
// The done state loads the output register once it is free. One request at a
// time; the next request is taken once the result sits in the output register.
// Reset: synchronous active-low aresetn restores the register defaults and
// clears all envelope state.
`default_nettype none

module ahdsr_envelope_generator
    import ahdsr_pkg::*;
#(
    parameter int TIME_BITS           = DEF_TIME_BITS,
    parameter int LEGATO_ATTACK_TICKS = DEF_LEGATO_ATTACK_TICKS,
    parameter int CFG_DATA_BITS       = (TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [0] note_start, [1] legato, [2] gate, [3] force_off, [7:4] zero
    input  wire logic [7:0]               s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [15:0] amplitude, [18:16] phase, [19] finished, [23:20] zero
    output logic [23:0]                   m_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CNT_BITS = TIME_BITS + 1;
    localparam int END_BITS = TIME_BITS + 3;

    // Configuration registers.
    logic [TIME_BITS-1:0] delay_reg, attack_reg, hold_reg, decay_reg;
    logic [TIME_BITS-1:0] release_reg, force_reg;
    logic [AMP_BITS-1:0]  sustain_reg;
    logic                 can_sustain_reg;

    // Envelope state.
    logic [CNT_BITS-1:0]  elapsed_reg, rel_count_reg;
    logic                 mark_reg;
    logic [AMP_BITS-1:0]  rel_level_reg;
    logic [TIME_BITS-1:0] active_attack_reg;

    // Per-request working registers.
    logic                 gate_reg, forced_reg;
    logic [END_BITS-1:0]  end_attack_reg, end_hold_reg, end_decay_reg;
    logic [AMP_BITS-1:0]  amp_reg;
    logic                 invert_reg, keep_level_reg, finished_reg;
    phase_t               phase_reg;
    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg;

    state_t state_reg, state_next;

    logic                 s_accept, out_free;
    logic [END_BITS-1:0]  t_ext, end_delay;
    logic [AMP_BITS-1:0]  sus;
    logic [TIME_BITS-1:0] forced_len, rel_len;
    logic [CNT_BITS-1:0]  rc_eff;
    logic                 hold_path, rel_silent, need_calc;
    logic [AMP_BITS-1:0]  direct_amp, op_a;
    logic [TIME_BITS-1:0] op_b, op_den;
    logic                 op_invert;
    phase_t               eval_phase;
    logic                 unit_done;
    logic [QUOT_BITS-1:0] unit_quot;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign sus        = (sustain_reg > FULL_LEVEL) ? FULL_LEVEL : sustain_reg;
    assign forced_len = (release_reg < force_reg) ? release_reg : force_reg;
    assign t_ext      = END_BITS'(elapsed_reg);
    assign end_delay  = END_BITS'(delay_reg);
    assign rc_eff     = mark_reg ? rel_count_reg : '0;
    assign rel_len    = forced_reg ? forced_len : release_reg;
    assign hold_path  = gate_reg && (can_sustain_reg || t_ext < end_decay_reg);
    assign rel_silent = (rel_len == '0) || (rc_eff >= CNT_BITS'(rel_len));

    // Segment selection and operand setup for the evaluation cycle.
    always_comb begin
        need_calc  = 1'b0;
        direct_amp = '0;
        op_a       = '0;
        op_b       = '0;
        op_den     = '0;
        op_invert  = 1'b0;
        eval_phase = PH_DELAY;
        if (forced_reg || !hold_path) begin
            eval_phase = forced_reg ? PH_FORCED : PH_RELEASE;
            if (!rel_silent) begin
                need_calc = 1'b1;
                op_a      = rel_level_reg;
                op_b      = TIME_BITS'(CNT_BITS'(rel_len) - rc_eff);
                op_den    = rel_len;
            end
        end else if (t_ext < end_delay) begin
            eval_phase = PH_DELAY;
        end else if (t_ext < end_attack_reg) begin
            eval_phase = PH_ATTACK;
            need_calc  = 1'b1;
            op_a       = FULL_LEVEL;
            op_b       = TIME_BITS'(t_ext - end_delay);
            op_den     = active_attack_reg;
        end else if (t_ext < end_hold_reg) begin
            eval_phase = PH_HOLD;
            direct_amp = FULL_LEVEL;
        end else if (t_ext < end_decay_reg) begin
            eval_phase = PH_DECAY;
            need_calc  = 1'b1;
            op_a       = FULL_LEVEL - sus;
            op_b       = TIME_BITS'(t_ext - end_hold_reg);
            op_den     = decay_reg;
            op_invert  = 1'b1;
        end else begin
            eval_phase = PH_SUSTAIN;
            direct_amp = sus;
        end
    end

    ahdsr_muldiv #(
        .TIME_BITS (TIME_BITS)
    ) u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_EVAL && need_calc),
        .mul_a    (op_a),
        .mul_b    (op_b),
        .divisor  (op_den),
        .done     (unit_done),
        .quotient (unit_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_END_ATTACK;
                end
            end
            ST_END_ATTACK: state_next = ST_END_HOLD;
            ST_END_HOLD:   state_next = ST_END_DECAY;
            ST_END_DECAY:  state_next = ST_EVAL;
            ST_EVAL:       state_next = need_calc ? ST_CALC : ST_DONE;
            ST_CALC: begin
                if (unit_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg       <= TIME_BITS'(RST_DELAY_TICKS);
            attack_reg      <= TIME_BITS'(RST_ATTACK_TICKS);
            hold_reg        <= TIME_BITS'(RST_HOLD_TICKS);
            decay_reg       <= TIME_BITS'(RST_DECAY_TICKS);
            sustain_reg     <= AMP_BITS'(RST_SUSTAIN_LEVEL);
            can_sustain_reg <= 1'b1;
            release_reg     <= TIME_BITS'(RST_RELEASE_TICKS);
            force_reg       <= TIME_BITS'(RST_FORCE_TICKS);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_DELAY:         delay_reg       <= cfg_data[TIME_BITS-1:0];
                CFG_ATTACK:        attack_reg      <= cfg_data[TIME_BITS-1:0];
                CFG_HOLD:          hold_reg        <= cfg_data[TIME_BITS-1:0];
                CFG_DECAY:         decay_reg       <= cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN_LEVEL: sustain_reg     <= cfg_data[AMP_BITS-1:0];
                CFG_CAN_SUSTAIN:   can_sustain_reg <= cfg_data[0];
                CFG_RELEASE:       release_reg     <= cfg_data[TIME_BITS-1:0];
                CFG_FORCE_RELEASE: force_reg       <= cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Envelope datapath, stepped by the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg       <= '0;
            rel_count_reg     <= '0;
            mark_reg          <= 1'b0;
            rel_level_reg     <= '0;
            active_attack_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        gate_reg   <= s_tdata[2];
                        forced_reg <= s_tdata[3];
                        if (s_tdata[0]) begin
                            elapsed_reg       <= '0;
                            rel_count_reg     <= '0;
                            mark_reg          <= 1'b0;
                            rel_level_reg     <= '0;
                            active_attack_reg <= s_tdata[1] ?
                                TIME_BITS'(LEGATO_ATTACK_TICKS) : attack_reg;
                        end
                    end
                end
                ST_END_ATTACK: begin
                    end_attack_reg <= end_delay + END_BITS'(active_attack_reg);
                end
                ST_END_HOLD: begin
                    end_hold_reg <= end_attack_reg + END_BITS'(hold_reg);
                end
                ST_END_DECAY: begin
                    end_decay_reg <= end_hold_reg + END_BITS'(decay_reg);
                end
                ST_EVAL: begin
                    phase_reg  <= eval_phase;
                    amp_reg    <= direct_amp;
                    invert_reg <= op_invert;
                    if (forced_reg || !hold_path) begin
                        mark_reg       <= 1'b1;
                        rel_count_reg  <= rc_eff;
                        keep_level_reg <= 1'b0;
                        finished_reg   <= rc_eff > CNT_BITS'(rel_len);
                    end else begin
                        mark_reg       <= 1'b0;
                        rel_count_reg  <= '0;
                        keep_level_reg <= 1'b1;
                        finished_reg   <= 1'b0;
                    end
                end
                ST_CALC: begin
                    if (unit_done) begin
                        amp_reg <= invert_reg ? FULL_LEVEL - unit_quot : unit_quot;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {4'b0000, finished_reg, phase_reg, amp_reg};
                        if (keep_level_reg) begin
                            rel_level_reg <= amp_reg;
                        end
                        if (elapsed_reg != '1) begin
                            elapsed_reg <= elapsed_reg + 1'b1;
                        end
                        if (mark_reg && rel_count_reg != '1) begin
                            rel_count_reg <= rel_count_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ahdsr_muldiv.sv =====
// Shared arithmetic unit: one registered multiply, then a restoring divide
// that retires one quotient bit per cycle. Depends on ahdsr_pkg.
`default_nettype none

module ahdsr_muldiv
    import ahdsr_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [AMP_BITS-1:0]   mul_a,
    input  wire logic [TIME_BITS-1:0]  mul_b,
    input  wire logic [TIME_BITS-1:0]  divisor,
    output logic                       done,
    output logic [QUOT_BITS-1:0]       quotient
);

    localparam int PROD_BITS = AMP_BITS + TIME_BITS;
    localparam int CNT_BITS  = $clog2(QUOT_BITS);

    logic [PROD_BITS-1:0] prod_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0] low_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 load_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [TIME_BITS:0]   trial;
    logic                 fits;

    // The caller guarantees the quotient fits in QUOT_BITS, so the upper part
    // of the product is already below the divisor.
    assign trial = {rem_reg, low_reg[QUOT_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && !load_reg && run_reg && (cnt_reg == '0);
            if (start) begin
                prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
                den_reg  <= divisor;
                load_reg <= 1'b1;
            end else if (load_reg) begin
                load_reg <= 1'b0;
                run_reg  <= 1'b1;
                rem_reg  <= prod_reg[PROD_BITS-1:QUOT_BITS];
                low_reg  <= prod_reg[QUOT_BITS-1:0];
                cnt_reg  <= CNT_BITS'(QUOT_BITS - 1);
            end else if (run_reg) begin
                if (fits) begin
                    rem_reg <= TIME_BITS'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[TIME_BITS-1:0];
                end
                low_reg  <= {low_reg[QUOT_BITS-2:0], 1'b0};
                quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/ahdsr_checker.sv =====
// Port-level checks for the AHDSR envelope generator, bound to the top level.
// Depends on ahdsr_pkg for field positions and phase codes.
`default_nettype none

module ahdsr_checker
    import ahdsr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic [2:0] out_phase;
    assign out_phase = m_tdata[OUT_PHASE_LSB +: 3];

    // One request is worked on at a time.
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while the previous one is in work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_amp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= FULL_LEVEL)
        else $error("amplitude above unity");

    // Finished is only reported during a release.
    a_finished_in_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_FIN_BIT] |->
            out_phase == PH_RELEASE || out_phase == PH_FORCED)
        else $error("finished flag outside a release");

endmodule

bind ahdsr_envelope_generator ahdsr_checker u_ahdsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ahdsr_envelope_generator: sample tick requests in, amplitude,
// phase and finished flag out, each result compared against a cycle-free envelope predictor.
// Depends on rtl/ahdsr_pkg.sv and the envelope generator with its arithmetic unit.

module testbench;
    import ahdsr_pkg::*;

    localparam int TIME_BITS    = DEF_TIME_BITS;
    localparam int CFG_BITS     = (TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS;
    localparam int RANDOM_TICKS = 1300;
    localparam int PHASE_TICKS  = 70;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [TIME_BITS:0]   COUNT_MAX = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

    typedef struct packed {
        logic [15:0] amplitude;
        phase_t      phase;
        logic        finished;
    } envelope_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    // Register copies held by the predictor.
    logic [TIME_BITS-1:0] delay_len, attack_len, hold_len, decay_len;
    logic [TIME_BITS-1:0] release_len, forced_release_len;
    logic [15:0]          sustain_amp;
    logic                 sustain_enable;

    // Envelope state held by the predictor.
    logic [TIME_BITS:0]   ticks_since_start;
    logic [TIME_BITS:0]   ticks_since_release;
    logic                 releasing;
    logic [15:0]          level_at_release;
    logic [TIME_BITS-1:0] latched_attack;

    envelope_result_t expected_envelope[$];

    int  ticks_sent, random_ticks, results_checked, mismatch_count, settings_written;
    bit  source_gaps, sink_stalls;
    int  stall_left;

    ahdsr_envelope_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TIME_MAX;
            2: return TIME_BITS'($urandom());
            default: return TIME_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] release_amplitude(longint unsigned len);
        if (len == 0 || ticks_since_release >= len)
            return '0;
        return 16'((level_at_release * (len - ticks_since_release)) / len);
    endfunction

    // Advances the envelope by one sample tick and returns what the block must emit.
    function automatic envelope_result_t advance_envelope(logic note_start, logic legato,
                                                          logic key_down, logic force_off);
        longint unsigned sus, short_len, t, end_delay, end_attack, end_hold, end_decay, amp;
        envelope_result_t res;
        sus = (sustain_amp > FULL_LEVEL) ? FULL_LEVEL : sustain_amp;
        short_len = (release_len < forced_release_len) ? release_len : forced_release_len;
        if (note_start) begin
            ticks_since_start   = '0;
            ticks_since_release = '0;
            releasing           = 1'b0;
            level_at_release    = '0;
            latched_attack      = legato ? TIME_BITS'(DEF_LEGATO_ATTACK_TICKS) : attack_len;
        end
        t          = ticks_since_start;
        end_delay  = delay_len;
        end_attack = end_delay + latched_attack;
        end_hold   = end_attack + hold_len;
        end_decay  = end_hold + decay_len;

        if (force_off) begin
            if (!releasing) begin
                releasing           = 1'b1;
                ticks_since_release = '0;
            end
            amp       = release_amplitude(short_len);
            res.phase = PH_FORCED;
        end else if (key_down && (sustain_enable || t < end_decay)) begin
            releasing           = 1'b0;
            ticks_since_release = '0;
            if (t < end_delay) begin
                amp       = 0;
                res.phase = PH_DELAY;
            end else if (t < end_attack) begin
                amp       = ((t - end_delay) * FULL_LEVEL) / latched_attack;
                res.phase = PH_ATTACK;
            end else if (t < end_hold) begin
                amp       = FULL_LEVEL;
                res.phase = PH_HOLD;
            end else if (t < end_decay) begin
                amp       = FULL_LEVEL - ((FULL_LEVEL - sus) * (t - end_hold)) / decay_len;
                res.phase = PH_DECAY;
            end else begin
                amp       = sus;
                res.phase = PH_SUSTAIN;
            end
            level_at_release = amp[15:0];
        end else begin
            if (!releasing) begin
                releasing           = 1'b1;
                ticks_since_release = '0;
            end
            amp       = release_amplitude(release_len);
            res.phase = PH_RELEASE;
        end

        res.amplitude = amp[15:0];
        res.finished  = releasing &&
                        (ticks_since_release > (force_off ? short_len : longint'(release_len)));

        if (ticks_since_start != COUNT_MAX)
            ticks_since_start++;
        if (releasing && ticks_since_release != COUNT_MAX)
            ticks_since_release++;
        return res;
    endfunction

    // Sends one sample tick request; valid stays high on return so back-to-back ticks
    // do not drop it between requests.
    task automatic send_tick(input logic note_start, input logic legato,
                             input logic key_down, input logic force_off);
        int gap;
        gap = (source_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, force_off, key_down, legato, note_start};
        do @(posedge aclk); while (!s_tready);
        expected_envelope.push_back(advance_envelope(note_start, legato, key_down, force_off));
        ticks_sent++;
    endtask

    task automatic wait_results_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_envelope.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DELAY:         delay_len          = value[TIME_BITS-1:0];
            CFG_ATTACK:        attack_len         = value[TIME_BITS-1:0];
            CFG_HOLD:          hold_len           = value[TIME_BITS-1:0];
            CFG_DECAY:         decay_len          = value[TIME_BITS-1:0];
            CFG_SUSTAIN_LEVEL: sustain_amp        = value[15:0];
            CFG_CAN_SUSTAIN:   sustain_enable     = value[0];
            CFG_RELEASE:       release_len        = value[TIME_BITS-1:0];
            CFG_FORCE_RELEASE: forced_release_len = value[TIME_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // With the reset registers and no note ever started the latched attack is zero,
    // so the envelope opens straight into the decay.
    task automatic test_before_first_note();
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Walks one note through every segment, a normal release running past its end,
    // a key press that cancels the release, and a forced close.
    task automatic test_envelope_segments();
        wait_results_idle();
        write_reg(CFG_DELAY, 2);
        write_reg(CFG_ATTACK, 3);
        write_reg(CFG_HOLD, 1);
        write_reg(CFG_DECAY, 2);
        write_reg(CFG_SUSTAIN_LEVEL, 10000);
        write_reg(CFG_CAN_SUSTAIN, 1);
        write_reg(CFG_RELEASE, 3);
        write_reg(CFG_FORCE_RELEASE, 1);
        settings_written++;
        send_tick(1'b1, 1'b0, 1'b1, 1'b0);
        repeat (8) send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        repeat (5) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    endtask

    // Sets no sustain, a zero release and a sustain register above unity; the note then only
    // reaches the hold before a legato start and a forced tick.
    task automatic test_no_sustain_and_legato();
        wait_results_idle();
        write_reg(CFG_ATTACK, 0);
        write_reg(CFG_DECAY, 1);
        write_reg(CFG_CAN_SUSTAIN, 0);
        write_reg(CFG_RELEASE, 0);
        write_reg(CFG_SUSTAIN_LEVEL, 16'hFFFF);
        settings_written++;
        send_tick(1'b1, 1'b0, 1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    endtask

    // Notes with random timing under random register settings, with noise ticks mixed in.
    task automatic test_random_envelopes();
        int              phase_no, phase_end, held, let_go;
        cfg_index_t      idx;
        logic [CFG_BITS-1:0] value;
        bit              forced_close;
        phase_no = 0;
        while (random_ticks < RANDOM_TICKS) begin
            wait_results_idle();
            for (int r = 0; r < 8; r++) begin
                idx = cfg_index_t'(r);
                case (idx)
                    CFG_SUSTAIN_LEVEL:
                        case ($urandom_range(0, 4))
                            0: value = 0;
                            1: value = CFG_BITS'(FULL_LEVEL);
                            2: value = CFG_BITS'($urandom_range(32769, 65535));
                            default: value = CFG_BITS'($urandom_range(0, 32768));
                        endcase
                    CFG_CAN_SUSTAIN: value = CFG_BITS'($urandom_range(0, 1));
                    default: value = pick_ticks();
                endcase
                // The first two settings are the all-zero and the all-maximum corners.
                if (phase_no == 0)
                    value = 0;
                else if (phase_no == 1)
                    value = (idx == CFG_SUSTAIN_LEVEL) ? CFG_BITS'(FULL_LEVEL) :
                            (idx == CFG_CAN_SUSTAIN) ? CFG_BITS'(1) : CFG_BITS'(TIME_MAX);
                write_reg(idx, value);
            end
            settings_written++;
            source_gaps = (phase_no % 3 != 1);
            sink_stalls = (phase_no % 3 != 2);
            phase_end = random_ticks + PHASE_TICKS;
            while (random_ticks < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        repeat ($urandom_range(1, 4)) begin
                            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                            random_ticks++;
                        end
                    end
                    2: wait_results_idle();
                    default: begin
                        held         = $urandom_range(0, 30);
                        let_go       = $urandom_range(0, 20);
                        forced_close = ($urandom_range(0, 3) == 0);
                        send_tick(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                                  $urandom_range(0, 15) == 0);
                        random_ticks++;
                        repeat (held) begin
                            send_tick(1'b0, 1'b0, 1'b1, $urandom_range(0, 39) == 0);
                            random_ticks++;
                        end
                        // A key pressed again during a normal release cancels it.
                        repeat (let_go) begin
                            send_tick(1'b0, 1'b0, $urandom_range(0, 24) == 0, forced_close);
                            random_ticks++;
                        end
                    end
                endcase
            end
            phase_no++;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        envelope_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_envelope.size() == 0) begin
                $error("result 0x%06h arrived with no request outstanding", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_envelope.pop_front();
                results_checked++;
                if (m_tdata[15:0] !== want.amplitude) begin
                    $error("amplitude: expected %0d, actual %0d", want.amplitude, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tdata[OUT_PHASE_LSB +: 3] !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase,
                           m_tdata[OUT_PHASE_LSB +: 3]);
                    mismatch_count++;
                end
                if (m_tdata[OUT_FIN_BIT] !== want.finished) begin
                    $error("finished: expected %0b, actual %0b", want.finished,
                           m_tdata[OUT_FIN_BIT]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int directed_ticks;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_DELAY;
        cfg_data   = '0;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        delay_len          = RST_DELAY_TICKS;
        attack_len         = RST_ATTACK_TICKS;
        hold_len           = RST_HOLD_TICKS;
        decay_len          = RST_DECAY_TICKS;
        sustain_amp        = RST_SUSTAIN_LEVEL;
        sustain_enable     = 1'b1;
        release_len        = RST_RELEASE_TICKS;
        forced_release_len = RST_FORCE_TICKS;
        ticks_since_start   = '0;
        ticks_since_release = '0;
        releasing           = 1'b0;
        level_at_release    = '0;
        latched_attack      = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_before_first_note();
        test_envelope_segments();
        test_no_sustain_and_legato();
        directed_ticks = ticks_sent;
        test_random_envelopes();
        wait_results_idle();

        $display("Sent %0d sample ticks (%0d directed, %0d random) under %0d register settings,",
                 ticks_sent, directed_ticks, random_ticks, settings_written);
        $display("with random gaps and output stalls; %0d results compared, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
